@@ hw/rtl/e8q_pkg.sv @@
package e8q_pkg;

  // Fixed geometry of the block.
  localparam int LANES    = 8;
  localparam int SAMPLE_W = 24;
  localparam int CFG_W    = 24;
  localparam int COORD_W  = 16;
  // Scaled sample: 25-bit difference times 24-bit unsigned step fits 49 signed bits.
  localparam int XW       = 49;

  localparam logic [CFG_W-1:0] INV_STEP_RESET = 24'd65536;
  localparam logic [CFG_W-1:0] CENTER_RESET   = 24'd0;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_CENTER   = 1'b0,
    CFG_INV_STEP = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic                        tail_block;
    logic signed [SAMPLE_W-1:0]  sample_7;
    logic signed [SAMPLE_W-1:0]  sample_6;
    logic signed [SAMPLE_W-1:0]  sample_5;
    logic signed [SAMPLE_W-1:0]  sample_4;
    logic signed [SAMPLE_W-1:0]  sample_3;
    logic signed [SAMPLE_W-1:0]  sample_2;
    logic signed [SAMPLE_W-1:0]  sample_1;
    logic signed [SAMPLE_W-1:0]  sample_0;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] coord_7;
    logic signed [COORD_W-1:0] coord_6;
    logic signed [COORD_W-1:0] coord_5;
    logic signed [COORD_W-1:0] coord_4;
    logic signed [COORD_W-1:0] coord_3;
    logic signed [COORD_W-1:0] coord_2;
    logic signed [COORD_W-1:0] coord_1;
    logic signed [COORD_W-1:0] coord_0;
  } out_t;

  // Load enables for the four stages inside the coset search.
  typedef struct packed {
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } adv_t;

endpackage

@@ hw/rtl/e8q_coset.sv @@
module e8q_coset #(
  parameter int FRACTION_BITS = 16,
  parameter bit HALF_SHIFT    = 1'b0
) (
  input  logic                                              clk,
  input  e8q_pkg::adv_t                                     adv,
  input  logic signed [e8q_pkg::XW-1:0]                     x_in [e8q_pkg::LANES],
  input  logic                                              fix_in,
  output logic signed [e8q_pkg::XW+1-FRACTION_BITS:0]       r_out [e8q_pkg::LANES],
  output logic [2*FRACTION_BITS+3:0]                        dist_out
);

  localparam int XW = e8q_pkg::XW;
  localparam int LN = e8q_pkg::LANES;
  localparam int RW = XW + 2 - FRACTION_BITS;
  localparam int EW = FRACTION_BITS + 2;
  localparam int SW = 2 * FRACTION_BITS + 1;
  localparam int DW = SW + 3;
  localparam int IW = $clog2(LN);

  localparam logic signed [XW:0]   HALF_X = signed'((XW+1)'(1) << (FRACTION_BITS - 1));
  localparam logic signed [XW:0]   SHIFT  = HALF_SHIFT ? HALF_X : '0;
  localparam logic signed [EW-1:0] ONE_E  = signed'(EW'(1) << FRACTION_BITS);

  logic signed [RW-1:0]            r3_r [LN];
  logic signed [RW-1:0]            r3_nxt [LN];
  logic signed [FRACTION_BITS:0]   e3_r [LN];
  logic signed [FRACTION_BITS:0]   e3_nxt [LN];
  logic                            fix3_r;
  logic signed [RW-1:0]            r4_r [LN];
  logic signed [RW-1:0]            r4_nxt [LN];
  logic signed [EW-1:0]            e4_r [LN];
  logic signed [EW-1:0]            e4_nxt [LN];
  logic signed [RW-1:0]            r5_r [LN];
  logic [SW-1:0]                   sq5_r [LN];
  logic [SW-1:0]                   sq5_nxt [LN];
  logic signed [RW-1:0]            r6_r [LN];
  logic [DW-1:0]                   dist6_r;
  logic [DW-1:0]                   dist6_nxt;

  // Round each lane half away from zero and keep the rounding error.
  always_comb begin
    logic signed [XW:0] y;
    logic signed [XW:0] t;
    logic signed [XW:0] e;
    for (int i = 0; i < LN; i++) begin
      y = (XW+1)'(x_in[i]) - SHIFT;
      t = y + HALF_X - (XW+1)'(y[XW]);
      r3_nxt[i] = RW'(t >>> FRACTION_BITS);
      e = y - ((XW+1)'(r3_nxt[i]) <<< FRACTION_BITS);
      e3_nxt[i] = e[FRACTION_BITS:0];
    end
  end

  // On odd parity, move the lane with the largest error one unit toward its value.
  always_comb begin
    logic [FRACTION_BITS:0] mag;
    logic [FRACTION_BITS:0] best;
    logic [IW-1:0]          worst;
    logic                   parity;
    best   = '0;
    worst  = '0;
    parity = 1'b0;
    for (int i = 0; i < LN; i++) begin
      mag = e3_r[i][FRACTION_BITS] ? unsigned'(-e3_r[i]) : unsigned'(e3_r[i]);
      if (i == 0 || mag > best) begin
        best  = mag;
        worst = IW'(i);
      end
      parity = parity ^ r3_r[i][0];
    end
    for (int i = 0; i < LN; i++) begin
      r4_nxt[i] = r3_r[i];
      e4_nxt[i] = EW'(e3_r[i]);
    end
    if (parity && fix3_r) begin
      if (e3_r[worst][FRACTION_BITS]) begin
        r4_nxt[worst] = r3_r[worst] - RW'(1);
        e4_nxt[worst] = EW'(e3_r[worst]) + ONE_E;
      end else begin
        r4_nxt[worst] = r3_r[worst] + RW'(1);
        e4_nxt[worst] = EW'(e3_r[worst]) - ONE_E;
      end
    end
  end

  // Squared error per lane.
  always_comb begin
    logic signed [2*EW-1:0] p;
    for (int i = 0; i < LN; i++) begin
      p = e4_r[i] * e4_r[i];
      sq5_nxt[i] = p[SW-1:0];
    end
  end

  // Squared distance to the coset point.
  always_comb begin
    dist6_nxt = '0;
    for (int i = 0; i < LN; i++) begin
      dist6_nxt = dist6_nxt + DW'(sq5_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      r3_r   <= r3_nxt;
      e3_r   <= e3_nxt;
      fix3_r <= fix_in;
    end
    if (adv.s4) begin
      r4_r <= r4_nxt;
      e4_r <= e4_nxt;
    end
    if (adv.s5) begin
      r5_r  <= r4_r;
      sq5_r <= sq5_nxt;
    end
    if (adv.s6) begin
      r6_r    <= r5_r;
      dist6_r <= dist6_nxt;
    end
  end

  assign r_out    = r6_r;
  assign dist_out = dist6_r;

endmodule

@@ hw/rtl/e8_lattice_block_quantizer.sv @@
// Channel  Handshake            Payload
// in_      in_valid / in_stall  e8q_pkg::in_t  (sample_0..7, tail_block)
// out_     out_valid / out_stall e8q_pkg::out_t (coord_0..7)
// cfg_     cfg_valid / cfg_ready cfg_index, cfg_data
//
// Seven register stages: subtract, multiply, round, parity fix, square, sum,
// select and saturate. One item per cycle while the output is not stalled.
// Each stage loads when it is empty or the stage after it moves, so bubbles close up
// and a stalled output holds while earlier stages keep filling.
// Synchronous active-low reset clears valid bits and sets the configuration registers.
module e8_lattice_block_quantizer #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  e8q_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output e8q_pkg::out_t               out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [0:0]                  cfg_index,
  input  logic [e8q_pkg::CFG_W-1:0]   cfg_data
);

  localparam int LN = e8q_pkg::LANES;
  localparam int XW = e8q_pkg::XW;
  localparam int SW = e8q_pkg::SAMPLE_W;
  localparam int CW = e8q_pkg::COORD_W;
  localparam int RW = XW + 2 - FRACTION_BITS;
  localparam int DW = 2 * FRACTION_BITS + 4;
  localparam logic signed [RW:0] SAT_HI = signed'((RW+1)'(32767));
  localparam logic signed [RW:0] SAT_LO = -signed'((RW+1)'(32768));

  logic [e8q_pkg::CFG_W-1:0] center_r;
  logic [e8q_pkg::CFG_W-1:0] inv_step_r;

  logic signed [SW-1:0] samp [LN];
  logic signed [SW:0]   d1_r [LN];
  logic signed [SW:0]   d1_nxt [LN];
  logic                 t1_r;
  logic signed [XW-1:0] x2_r [LN];
  logic signed [XW-1:0] x2_nxt [LN];
  logic                 t2_r, t3_r, t4_r, t5_r, t6_r;
  logic [6:1]           v_r;
  logic                 out_valid_r;
  e8q_pkg::out_t        out_r;
  e8q_pkg::out_t        out_nxt;
  logic [7:1]           adv;
  e8q_pkg::adv_t        cadv;

  logic signed [RW-1:0] ra [LN];
  logic signed [RW-1:0] rb [LN];
  logic [DW-1:0]        da;
  logic [DW-1:0]        db;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r   <= e8q_pkg::CENTER_RESET;
      inv_step_r <= e8q_pkg::INV_STEP_RESET;
    end else if (cfg_valid) begin
      case (e8q_pkg::cfg_reg_t'(cfg_index))
        e8q_pkg::CFG_CENTER:   center_r   <= cfg_data;
        e8q_pkg::CFG_INV_STEP: inv_step_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage load enables, from the output back.
  always_comb begin
    adv[7] = !out_valid_r || !out_stall;
    for (int k = 6; k >= 1; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end
  assign in_stall = !adv[1];
  assign cadv     = '{s3: adv[3], s4: adv[4], s5: adv[5], s6: adv[6]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv[1]) v_r[1] <= in_valid;
      for (int k = 2; k <= 6; k++) begin
        if (adv[k]) v_r[k] <= v_r[k-1];
      end
      if (adv[7]) out_valid_r <= v_r[6];
    end
  end

  assign samp[0] = in_data.sample_0;
  assign samp[1] = in_data.sample_1;
  assign samp[2] = in_data.sample_2;
  assign samp[3] = in_data.sample_3;
  assign samp[4] = in_data.sample_4;
  assign samp[5] = in_data.sample_5;
  assign samp[6] = in_data.sample_6;
  assign samp[7] = in_data.sample_7;

  // Remove the center from each sample.
  always_comb begin
    for (int i = 0; i < LN; i++) begin
      d1_nxt[i] = (SW+1)'(samp[i]) - (SW+1)'(signed'(center_r));
    end
  end

  // Scale by the reciprocal step.
  always_comb begin
    logic signed [2*SW+1:0] p;
    for (int i = 0; i < LN; i++) begin
      p = d1_r[i] * signed'({1'b0, inv_step_r});
      x2_nxt[i] = p[XW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      d1_r <= d1_nxt;
      t1_r <= in_data.tail_block;
    end
    if (adv[2]) begin
      x2_r <= x2_nxt;
      t2_r <= t1_r;
    end
    if (adv[3]) t3_r <= t2_r;
    if (adv[4]) t4_r <= t3_r;
    if (adv[5]) t5_r <= t4_r;
    if (adv[6]) t6_r <= t5_r;
    if (adv[7]) out_r <= out_nxt;
  end

  // Integer coset; a tail item skips the parity fix and rounds lanes alone.
  e8q_coset #(
    .FRACTION_BITS (FRACTION_BITS),
    .HALF_SHIFT    (1'b0)
  ) u_coset_a (
    .clk      (clk),
    .adv      (cadv),
    .x_in     (x2_r),
    .fix_in   (!t2_r),
    .r_out    (ra),
    .dist_out (da)
  );

  // Half-integer coset.
  e8q_coset #(
    .FRACTION_BITS (FRACTION_BITS),
    .HALF_SHIFT    (1'b1)
  ) u_coset_b (
    .clk      (clk),
    .adv      (cadv),
    .x_in     (x2_r),
    .fix_in   (1'b1),
    .r_out    (rb),
    .dist_out (db)
  );

  // Pick the closer coset, ties and tail items to the integer one, then double and saturate.
  always_comb begin
    logic signed [RW:0]   v;
    logic signed [CW-1:0] c [LN];
    logic                 use_b;
    use_b = !t6_r && (db < da);
    for (int i = 0; i < LN; i++) begin
      if (use_b) v = ((RW+1)'(rb[i]) <<< 1) + (RW+1)'(1);
      else       v = (RW+1)'(ra[i]) <<< 1;
      if (v > SAT_HI)      c[i] = CW'(SAT_HI);
      else if (v < SAT_LO) c[i] = CW'(SAT_LO);
      else                 c[i] = v[CW-1:0];
    end
    out_nxt.coord_0 = c[0];
    out_nxt.coord_1 = c[1];
    out_nxt.coord_2 = c[2];
    out_nxt.coord_3 = c[3];
    out_nxt.coord_4 = c[4];
    out_nxt.coord_5 = c[5];
    out_nxt.coord_6 = c[6];
    out_nxt.coord_7 = c[7];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ tb/sv/testbench.sv @@
module testbench;

  localparam int FB = 16;
  localparam longint ONE_FX = 64'sd1 <<< FB;
  localparam longint HALF_FX = ONE_FX >>> 1;
  localparam int N_PHASES = 9;
  localparam int ITEMS_PER_PHASE = 115;

  typedef struct {
    e8q_pkg::in_t  item;
    bit            known;
    e8q_pkg::out_t want;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  e8q_pkg::in_t  in_data;
  logic out_valid;
  logic out_stall;
  e8q_pkg::out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [0:0] cfg_index;
  logic [e8q_pkg::CFG_W-1:0] cfg_data;

  // Shadow copies of the configuration registers.
  logic signed [e8q_pkg::CFG_W-1:0] center_q;
  logic [e8q_pkg::CFG_W-1:0] step_q;

  e8q_pkg::out_t coords_q[$];
  int errors;
  bit quiet;
  bit hold_long;

  e8_lattice_block_quantizer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("FAIL e8_lattice_block_quantizer");
    $finish;
  end

  // Round a fixed-point value to an integer, half away from zero.
  function automatic longint round_away(longint v);
    if (v >= 0) return (v + HALF_FX) / ONE_FX;
    return -((-v + HALF_FX) / ONE_FX);
  endfunction

  // Nearest point with an even coordinate sum; returns the squared distance.
  function automatic longint nearest_even_sum(input longint v[8], output longint r[8]);
    longint err[8];
    longint mag;
    longint worst_mag;
    int worst;
    bit par;
    longint sq_sum;
    worst = 0;
    worst_mag = 0;
    par = 1'b0;
    sq_sum = 0;
    for (int i = 0; i < 8; i++) begin
      r[i] = round_away(v[i]);
      err[i] = v[i] - r[i] * ONE_FX;
      mag = (err[i] < 0) ? -err[i] : err[i];
      if (i == 0 || mag > worst_mag) begin
        worst_mag = mag;
        worst = i;
      end
      par ^= r[i][0];
    end
    // Odd sum: push the worst lane one unit toward its value.
    if (par) begin
      if (err[worst] < 0) begin
        r[worst] -= 1;
        err[worst] += ONE_FX;
      end else begin
        r[worst] += 1;
        err[worst] -= ONE_FX;
      end
    end
    for (int i = 0; i < 8; i++) sq_sum += err[i] * err[i];
    return sq_sum;
  endfunction

  function automatic logic [e8q_pkg::COORD_W-1:0] clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[e8q_pkg::COORD_W-1:0];
  endfunction

  // Expected coordinates of one block under the current register values.
  function automatic e8q_pkg::out_t quantize_block(e8q_pkg::in_t it);
    longint x[8];
    longint y[8];
    longint a[8];
    longint b[8];
    longint c;
    longint k;
    longint sv;
    longint da;
    longint db;
    logic signed [e8q_pkg::SAMPLE_W-1:0] s;
    e8q_pkg::out_t o;
    c = center_q;
    k = step_q;
    for (int i = 0; i < 8; i++) begin
      s = it[i*e8q_pkg::SAMPLE_W +: e8q_pkg::SAMPLE_W];
      sv = s;
      x[i] = (sv - c) * k;
      y[i] = x[i] - HALF_FX;
    end
    if (it.tail_block) begin
      for (int i = 0; i < 8; i++)
        o[i*e8q_pkg::COORD_W +: e8q_pkg::COORD_W] = clamp16(2 * round_away(x[i]));
    end else begin
      da = nearest_even_sum(x, a);
      db = nearest_even_sum(y, b);
      for (int i = 0; i < 8; i++) begin
        if (db < da) o[i*e8q_pkg::COORD_W +: e8q_pkg::COORD_W] = clamp16(2 * b[i] + 1);
        else o[i*e8q_pkg::COORD_W +: e8q_pkg::COORD_W] = clamp16(2 * a[i]);
      end
    end
    return o;
  endfunction

  function automatic e8q_pkg::in_t fill_lanes(logic [e8q_pkg::SAMPLE_W-1:0] v, bit tail);
    e8q_pkg::in_t it;
    for (int i = 0; i < 8; i++) it[i*e8q_pkg::SAMPLE_W +: e8q_pkg::SAMPLE_W] = v;
    it.tail_block = tail;
    return it;
  endfunction

  function automatic e8q_pkg::out_t fill_coords(logic [e8q_pkg::COORD_W-1:0] v);
    e8q_pkg::out_t o;
    for (int i = 0; i < 8; i++) o[i*e8q_pkg::COORD_W +: e8q_pkg::COORD_W] = v;
    return o;
  endfunction

  // Random block: mostly samples near the center so the lattice search matters.
  function automatic e8q_pkg::in_t random_block();
    e8q_pkg::in_t it;
    longint span;
    longint off;
    span = (step_q == 0) ? 64'sd4000 : (64'sd1050000000 / longint'(step_q)) + 2;
    if (span > 64'sd8388607) span = 64'sd8388607;
    if ($urandom_range(0, 4) == 0) span = 3;
    for (int i = 0; i < 8; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        it[i*e8q_pkg::SAMPLE_W +: e8q_pkg::SAMPLE_W] = e8q_pkg::SAMPLE_W'($urandom);
      end else begin
        off = longint'($urandom_range(0, 32'(2 * span))) - span;
        it[i*e8q_pkg::SAMPLE_W +: e8q_pkg::SAMPLE_W] =
          e8q_pkg::SAMPLE_W'(longint'(center_q) + off);
      end
    end
    it.tail_block = ($urandom_range(0, 4) == 0);
    return it;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  // Offer one item and wait until it is taken.
  task automatic send_block(e8q_pkg::in_t it, bit known, e8q_pkg::out_t want);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    coords_q.push_back(known ? want : quantize_block(it));
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic drain();
    if (in_valid) in_valid <= 1'b0;
    while (coords_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(e8q_pkg::cfg_reg_t idx, logic [e8q_pkg::CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == e8q_pkg::CFG_CENTER) center_q = value;
    else step_q = value;
    @(posedge clk);
  endtask

  // Result checker.
  always @(posedge clk) begin
    e8q_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (coords_q.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = coords_q.pop_front();
        for (int i = 0; i < 8; i++) begin
          if (out_data[i*e8q_pkg::COORD_W +: e8q_pkg::COORD_W] !==
              want[i*e8q_pkg::COORD_W +: e8q_pkg::COORD_W])
            report_mismatch($sformatf("coord_%0d got %0d want %0d", i,
              $signed(out_data[i*e8q_pkg::COORD_W +: e8q_pkg::COORD_W]),
              $signed(want[i*e8q_pkg::COORD_W +: e8q_pkg::COORD_W])));
        end
      end
    end
  end

  // Receiver: random stall bursts, one long hold on request.
  initial begin
    out_stall <= 1'b0;
    forever begin
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (150) @(posedge clk);
        hold_long = 1'b0;
      end else if (quiet || $urandom_range(0, 2) != 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
    end
  end

  initial begin
    stim_row_t rows[14];
    int centers[N_PHASES];
    int steps[N_PHASES];
    e8q_pkg::out_t zeros;
    e8q_pkg::out_t top;
    e8q_pkg::out_t bottom;
    errors = 0;
    quiet = 1'b0;
    hold_long = 1'b0;
    center_q = e8q_pkg::CENTER_RESET;
    step_q = e8q_pkg::INV_STEP_RESET;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= e8q_pkg::CFG_CENTER;
    cfg_data <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table; coordinates typed in where they are obvious.
    zeros = fill_coords(16'sh0000);
    top = fill_coords(16'sh7fff);
    bottom = fill_coords(16'sh8000);
    rows[0] = '{fill_lanes(24'h000000, 1'b0), 1'b1, zeros};
    rows[1] = '{fill_lanes(24'h000000, 1'b1), 1'b1, zeros};
    rows[2] = '{fill_lanes(24'h7fffff, 1'b1), 1'b1, top};
    rows[3] = '{fill_lanes(24'h7fffff, 1'b0), 1'b1, top};
    rows[4] = '{fill_lanes(24'h800000, 1'b1), 1'b1, bottom};
    rows[5] = '{fill_lanes(24'h800000, 1'b0), 1'b1, bottom};
    rows[6] = '{fill_lanes(24'h000001, 1'b0), 1'b0, zeros};
    rows[7] = '{fill_lanes(24'hffffff, 1'b1), 1'b0, zeros};
    rows[8] = '{fill_lanes(24'h555555, 1'b0), 1'b0, zeros};
    rows[9] = '{fill_lanes(24'haaaaaa, 1'b1), 1'b0, zeros};
    rows[10] = '{fill_lanes(24'h000000, 1'b0), 1'b0, zeros};
    rows[10].item.sample_3 = 24'sd1;
    rows[11] = '{fill_lanes(24'h000003, 1'b0), 1'b0, zeros};
    rows[11].item.sample_0 = -24'sd2;
    rows[12] = '{fill_lanes(24'h7fffff, 1'b0), 1'b0, zeros};
    rows[12].item.sample_1 = 24'sh800000;
    rows[13] = '{fill_lanes(24'h001000, 1'b1), 1'b0, zeros};
    rows[13].item.sample_7 = -24'sd4097;
    foreach (rows[i]) send_block(rows[i].item, rows[i].known, rows[i].want);
    drain();

    // Same table at half step: every odd sample lands on a rounding tie.
    write_reg(e8q_pkg::CFG_INV_STEP, 24'd32768);
    foreach (rows[i]) send_block(rows[i].item, 1'b0, zeros);
    drain();

    // Register settings per phase, extremes among them.
    centers = '{0, 0, -8388608, 8388607, 0, 0, -12345, 0, 0};
    steps = '{65536, 0, 16777215, 1, 32768, 16777215, 98304, 0, 65536};
    for (int p = 3; p < N_PHASES; p++) centers[p] = int'($urandom_range(0, 4000)) - 2000;
    centers[5] = 0;
    steps[7] = $urandom_range(1000, 300000);
    for (int p = 0; p < N_PHASES; p++) begin
      write_reg(e8q_pkg::CFG_CENTER, e8q_pkg::CFG_W'(centers[p]));
      write_reg(e8q_pkg::CFG_INV_STEP, e8q_pkg::CFG_W'(steps[p]));
      if (p == 0) hold_long = 1'b1;
      if (p == N_PHASES - 1) quiet = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_block(random_block(), 1'b0, zeros);
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) $display("PASS e8_lattice_block_quantizer");
    else $display("FAIL e8_lattice_block_quantizer");
    $finish;
  end

endmodule
